@@ rtl/core/psenc_pkg.sv @@
// ----------------------------------------------------------------------------
// psenc_pkg
// Types and constants shared by the pixel row span encoder.
// ----------------------------------------------------------------------------
package psenc_pkg;

	localparam int COL_W      = 10;
	localparam int ROW_W      = 10;
	localparam int SPAN_Y_W   = 11;
	localparam int COLOR_W    = 3;
	localparam int REPEAT_W   = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	// Largest horizontal widening, and largest number of row copies per span
	localparam int MAX_REPEAT = 8;
	localparam int COPY_LIMIT = 8;
	localparam int COPY_CAP   = (MAX_REPEAT < COPY_LIMIT) ? MAX_REPEAT : COPY_LIMIT;
	localparam int COPY_W     = (COPY_CAP > 1) ? $clog2(COPY_CAP) : 1;
	localparam int XR_W       = $clog2(MAX_REPEAT + 1);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIRST_X          = 3'd0,
		REG_LAST_X           = 3'd1,
		REG_X_REPEAT         = 3'd2,
		REG_Y_REPEAT         = 3'd3,
		REG_BACKGROUND_COLOR = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [COL_W-1:0]    first_x;
		logic [COL_W-1:0]    last_x;
		logic [REPEAT_W-1:0] x_repeat;
		logic [REPEAT_W-1:0] y_repeat;
		logic [COLOR_W-1:0]  background_color;
	} cfg_t;

	// One pixel's work for the back end: a run closed by a colour change
	// and a run closed by the end of the row, each optional.
	typedef struct packed {
		logic               has_a;
		logic [COL_W-1:0]   a_xs;
		logic [COL_W-1:0]   a_xe;
		logic [COLOR_W-1:0] a_color;
		logic               has_b;
		logic [COL_W-1:0]   b_xs;
		logic [COL_W-1:0]   b_xe;
		logic [COLOR_W-1:0] b_color;
		logic [ROW_W-1:0]   row_y;
		logic [COPY_W-1:0]  copy_last;
	} span_cmd_t;

	typedef struct packed {
		logic full;
		logic head_valid;
	} queue_stat_t;

endpackage

@@ rtl/core/psenc_pixel_if.sv @@
// ----------------------------------------------------------------------------
// psenc_pixel_if
// Input channel: one source pixel per transfer.
// ----------------------------------------------------------------------------
interface psenc_pixel_if
	import psenc_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] pixel_color;
	logic [ROW_W-1:0]   row_y;

	modport source (output valid, output pixel_color, output row_y, input ready);
	modport sink   (input valid, input pixel_color, input row_y, output ready);
endinterface

@@ rtl/core/psenc_span_if.sv @@
// ----------------------------------------------------------------------------
// psenc_span_if
// Output channel: one horizontal span copy per transfer.
// ----------------------------------------------------------------------------
interface psenc_span_if
	import psenc_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [COL_W-1:0]    span_x_start;
	logic [COL_W-1:0]    span_x_end;
	logic [SPAN_Y_W-1:0] span_y;
	logic [COLOR_W-1:0]  span_color;
	logic                row_done;
	logic                last_of_run;

	modport source (output valid, output span_x_start, output span_x_end, output span_y,
		output span_color, output row_done, output last_of_run, input ready);
	modport sink   (input valid, input span_x_start, input span_x_end, input span_y,
		input span_color, input row_done, input last_of_run, output ready);
endinterface

@@ rtl/core/psenc_front.sv @@
// ----------------------------------------------------------------------------
// psenc_front
// Tracks the open run and column position; turns each pixel into a command
// holding the runs it closes.
// ----------------------------------------------------------------------------
module psenc_front
	import psenc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	psenc_pixel_if.sink         pixel,
	input  queue_stat_t         q_stat,
	output logic                push,
	output span_cmd_t           cmd
);

	logic [COL_W-1:0]   next_col_q;
	logic [COL_W-1:0]   run_start_q;
	logic [COLOR_W-1:0] run_color_q;
	logic               run_open_q;

	logic               accept;
	logic               color_change;
	logic [COL_W-1:0]   col_now;
	logic [COL_W-1:0]   start_new;
	logic [XR_W-1:0]    xr;
	logic [COPY_W:0]    yr;
	logic [COL_W:0]     end_col;
	logic               row_end;

	assign pixel.ready = !q_stat.full;
	assign accept      = pixel.valid && pixel.ready;

	// Clamp repeats to their legal ranges
	always_comb begin
		if (cfg.x_repeat == '0) begin
			xr = XR_W'(1);
		end else if (int'(cfg.x_repeat) > MAX_REPEAT) begin
			xr = XR_W'(MAX_REPEAT);
		end else begin
			xr = XR_W'(cfg.x_repeat);
		end
		if (cfg.y_repeat == '0) begin
			yr = (COPY_W+1)'(1);
		end else if (int'(cfg.y_repeat) > COPY_CAP) begin
			yr = (COPY_W+1)'(COPY_CAP);
		end else begin
			yr = (COPY_W+1)'(cfg.y_repeat);
		end
	end

	always_comb begin
		color_change = run_open_q && (pixel.pixel_color != run_color_q);
		col_now      = run_open_q ? next_col_q : cfg.first_x;
		if (!run_open_q) begin
			start_new = cfg.first_x;
		end else if (color_change) begin
			start_new = next_col_q;
		end else begin
			start_new = run_start_q;
		end
		end_col = {1'b0, col_now} + (COL_W+1)'(xr) - (COL_W+1)'(1);
		row_end = end_col >= {1'b0, cfg.last_x};

		cmd.has_a     = color_change && (run_color_q != cfg.background_color);
		cmd.a_xs      = run_start_q;
		cmd.a_xe      = next_col_q - COL_W'(1);
		cmd.a_color   = run_color_q;
		cmd.has_b     = row_end && (pixel.pixel_color != cfg.background_color);
		cmd.b_xs      = start_new;
		// A run that starts past the last column closes as one column
		cmd.b_xe      = (cfg.last_x < start_new) ? start_new : cfg.last_x;
		cmd.b_color   = pixel.pixel_color;
		cmd.row_y     = pixel.row_y;
		cmd.copy_last = COPY_W'(yr - (COPY_W+1)'(1));
	end

	assign push = accept && (cmd.has_a || cmd.has_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_col_q  <= '0;
			run_start_q <= '0;
			run_color_q <= '0;
			run_open_q  <= 1'b0;
		end else if (accept) begin
			run_start_q <= start_new;
			run_color_q <= pixel.pixel_color;
			if (row_end) begin
				next_col_q <= cfg.first_x;
				run_open_q <= 1'b0;
			end else begin
				next_col_q <= end_col[COL_W-1:0] + COL_W'(1);
				run_open_q <= 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/psenc_queue.sv @@
// ----------------------------------------------------------------------------
// psenc_queue
// Short FIFO of span commands between the front and the back end.
// ----------------------------------------------------------------------------
module psenc_queue
	import psenc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  span_cmd_t   push_cmd,
	input  logic        pop,
	output span_cmd_t   head_cmd,
	output queue_stat_t stat
);

	span_cmd_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign stat.full       = count_q == QCNT_W'(QUEUE_DEPTH);
	assign stat.head_valid = count_q != '0;
	assign head_cmd        = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

@@ rtl/core/psenc_back.sv @@
// ----------------------------------------------------------------------------
// psenc_back
// Expands each queued command into its row copies, one per cycle while the
// output is not stalled, through an output register.
// ----------------------------------------------------------------------------
module psenc_back
	import psenc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  span_cmd_t   head_cmd,
	input  queue_stat_t q_stat,
	output logic        pop,
	psenc_span_if.source span
);

	logic                out_valid_q;
	logic                phase_b_q;
	logic [COPY_W-1:0]   copy_q;
	logic [COL_W-1:0]    xs_q;
	logic [COL_W-1:0]    xe_q;
	logic [SPAN_Y_W-1:0] y_q;
	logic [COLOR_W-1:0]  color_q;
	logic                row_done_q;
	logic                last_q;

	logic                load;
	logic                use_b;
	logic                last_copy;
	logic                final_copy;

	assign use_b      = phase_b_q || !head_cmd.has_a;
	assign last_copy  = copy_q == head_cmd.copy_last;
	assign final_copy = last_copy && (use_b || !head_cmd.has_b);
	assign load       = q_stat.head_valid && (!out_valid_q || span.ready);
	assign pop        = load && final_copy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_b_q   <= 1'b0;
			copy_q      <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (span.ready) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				if (last_copy) begin
					copy_q    <= '0;
					// move on to the row-end run, or drop back for the next command
					phase_b_q <= !final_copy;
				end else begin
					copy_q <= copy_q + COPY_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			xs_q       <= use_b ? head_cmd.b_xs : head_cmd.a_xs;
			xe_q       <= use_b ? head_cmd.b_xe : head_cmd.a_xe;
			color_q    <= use_b ? head_cmd.b_color : head_cmd.a_color;
			y_q        <= SPAN_Y_W'(head_cmd.row_y) + SPAN_Y_W'(copy_q);
			row_done_q <= use_b;
			last_q     <= final_copy;
		end
	end

	assign span.valid        = out_valid_q;
	assign span.span_x_start = xs_q;
	assign span.span_x_end   = xe_q;
	assign span.span_y       = y_q;
	assign span.span_color   = color_q;
	assign span.row_done     = row_done_q;
	assign span.last_of_run  = last_q;

endmodule

@@ rtl/core/pixel_row_span_encoder_top.sv @@
// ----------------------------------------------------------------------------
// pixel_row_span_encoder_top
// Run-length span encoder for a widened pixel row stream.
// ----------------------------------------------------------------------------
// A pixel is taken every cycle while the four-entry command queue has room;
// a pixel that closes no drawn run leaves nothing queued. A pixel that closes
// a drawn run produces y_repeat span copies (clamped to 1..8), and one that
// closes two drawn runs (colour change and row end together) produces twice
// that; the expansion stage sends one copy per cycle while the span output is
// ready, and that copy loop bounds the sustained pixel rate. A pixel's first
// span passes through the command queue and then the output register. Writes
// to indexes 5 to 7 are ignored. The user must write configuration registers
// through cfg_we/cfg_index/cfg_wdata only while idle; this is not enforced.
module pixel_row_span_encoder_top
	import psenc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	psenc_pixel_if.sink           pixel,
	psenc_span_if.source          span
);

	cfg_t        cfg_q;
	logic        push;
	logic        pop;
	span_cmd_t   push_cmd;
	span_cmd_t   head_cmd;
	queue_stat_t q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_x          <= '0;
			cfg_q.last_x           <= COL_W'(1023);
			cfg_q.x_repeat         <= REPEAT_W'(1);
			cfg_q.y_repeat         <= REPEAT_W'(1);
			cfg_q.background_color <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_FIRST_X:          cfg_q.first_x          <= cfg_wdata[COL_W-1:0];
				REG_LAST_X:           cfg_q.last_x           <= cfg_wdata[COL_W-1:0];
				REG_X_REPEAT:         cfg_q.x_repeat         <= cfg_wdata[REPEAT_W-1:0];
				REG_Y_REPEAT:         cfg_q.y_repeat         <= cfg_wdata[REPEAT_W-1:0];
				REG_BACKGROUND_COLOR: cfg_q.background_color <= cfg_wdata[COLOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	psenc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.pixel  (pixel),
		.q_stat (q_stat),
		.push   (push),
		.cmd    (push_cmd)
	);

	psenc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.stat     (q_stat)
	);

	psenc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_cmd (head_cmd),
		.q_stat   (q_stat),
		.pop      (pop),
		.span     (span)
	);

endmodule

@@ rtl/core/psenc_checker.sv @@
// ----------------------------------------------------------------------------
// psenc_checker
// Port-level checks on the span output of the encoder.
// ----------------------------------------------------------------------------
module psenc_checker
	import psenc_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                span_valid,
	input logic                span_ready,
	input logic [COL_W-1:0]    span_x_start,
	input logic [COL_W-1:0]    span_x_end,
	input logic [SPAN_Y_W-1:0] span_y,
	input logic [COLOR_W-1:0]  span_color,
	input logic                row_done,
	input logic                last_of_run
);

	logic span_xfer;
	assign span_xfer = span_valid && span_ready;

	// Output register is cleared while reset is held
	assert property (@(posedge clk) !arst_n |-> !span_valid)
		else $error("span valid during reset");

	// Hold a stalled span
	assert property (@(posedge clk) disable iff (!arst_n)
		span_valid && !span_ready |=> span_valid && $stable(span_x_start)
			&& $stable(span_x_end) && $stable(span_y) && $stable(span_color)
			&& $stable(row_done) && $stable(last_of_run))
		else $error("stalled span changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		span_valid |-> span_x_start <= span_x_end)
		else $error("span ends before it starts");

	// Row-end copies follow back to back on consecutive rows
	assert property (@(posedge clk) disable iff (!arst_n)
		span_xfer && row_done && !last_of_run |=> span_valid && row_done
			&& span_y == $past(span_y) + SPAN_Y_W'(1))
		else $error("row-end copy sequence broken");

endmodule

bind pixel_row_span_encoder_top psenc_checker u_psenc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.span_valid   (span.valid),
	.span_ready   (span.ready),
	.span_x_start (span.span_x_start),
	.span_x_end   (span.span_x_end),
	.span_y       (span.span_y),
	.span_color   (span.span_color),
	.row_done     (span.row_done),
	.last_of_run  (span.last_of_run)
);

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for pixel_row_span_encoder_top. A scoreboard predicts
// the span copies that each transferred pixel produces and checks every span
// transfer against them in order. A short directed run comes first, then
// random rows under three flow-control regimes and changing register settings.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import psenc_pkg::*;

	localparam int QUIET_LIMIT     = 4000;
	localparam int SETTLE_CYCLES   = 8;
	localparam int PRESSURE_CYCLES = 300;
	localparam int PHASE_PIXELS    = 42;

	typedef struct packed {
		logic [COL_W-1:0]    x_start;
		logic [COL_W-1:0]    x_end;
		logic [SPAN_Y_W-1:0] y;
		logic [COLOR_W-1:0]  color;
		logic                row_done;
		logic                last_of_run;
	} span_t;

	function automatic string span_text(span_t s);
		return $sformatf("x %0d..%0d y %0d colour %0d row_done %0d last %0d",
			s.x_start, s.x_end, s.y, s.color, s.row_done, s.last_of_run);
	endfunction

	class span_scoreboard;
		logic [COL_W-1:0]    first_col;
		logic [COL_W-1:0]    last_col;
		logic [REPEAT_W-1:0] x_rep;
		logic [REPEAT_W-1:0] y_rep;
		logic [COLOR_W-1:0]  bg_color;
		logic [COL_W-1:0]    next_col;
		logic [COL_W-1:0]    run_start;
		logic [COLOR_W-1:0]  run_color;
		bit                  run_open;
		span_t               spans_due[$];
		int                  errors;

		function new();
			first_col = '0;
			last_col  = '1;
			x_rep     = REPEAT_W'(1);
			y_rep     = REPEAT_W'(1);
			bg_color  = '0;
			next_col  = '0;
			run_start = '0;
			run_color = '0;
			run_open  = 1'b0;
			errors    = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_FIRST_X: first_col = data[COL_W-1:0];
			REG_LAST_X: last_col = data[COL_W-1:0];
			REG_X_REPEAT: x_rep = data[REPEAT_W-1:0];
			REG_Y_REPEAT: y_rep = data[REPEAT_W-1:0];
			REG_BACKGROUND_COLOR: bg_color = data[COLOR_W-1:0];
			default: ;
			endcase
		endfunction

		function int unsigned clamp_rep(logic [REPEAT_W-1:0] v, int unsigned cap);
			if (v == 0)
				return 1;
			if (v > cap)
				return cap;
			return 32'(v);
		endfunction

		// Queue the row copies of the run just closed; background runs vanish
		function void queue_copies(logic [COL_W-1:0] xs, logic [COL_W-1:0] xe,
			logic [ROW_W-1:0] ry, bit closes_row);
			span_t       s;
			int unsigned copies;
			copies = clamp_rep(y_rep, COPY_CAP);
			if (run_color == bg_color)
				return;
			for (int unsigned k = 0; k < copies; k++) begin
				s.x_start     = xs;
				s.x_end       = xe;
				s.y           = SPAN_Y_W'(ry) + SPAN_Y_W'(k);
				s.color       = run_color;
				s.row_done    = closes_row;
				s.last_of_run = 1'b0;
				spans_due.push_back(s);
			end
		endfunction

		function void note_pixel(logic [COLOR_W-1:0] color, logic [ROW_W-1:0] ry);
			int unsigned xr;
			int unsigned reach;
			int          n_prior;
			span_t       tail;
			n_prior = spans_due.size();
			xr = clamp_rep(x_rep, MAX_REPEAT);
			if (!run_open) begin
				next_col  = first_col;
				run_start = first_col;
				run_color = color;
				run_open  = 1'b1;
			end else if (color != run_color) begin
				queue_copies(run_start, COL_W'(next_col - 1'b1), ry, 1'b0);
				run_start = next_col;
				run_color = color;
			end
			reach = int'(next_col) + xr - 1;
			if (reach >= last_col) begin
				// a run opened past last_x collapses to its start column
				queue_copies(run_start, (last_col < run_start) ? run_start : last_col, ry, 1'b1);
				next_col = first_col;
				run_open = 1'b0;
			end else begin
				next_col = COL_W'(reach + 1);
			end
			if (spans_due.size() > n_prior) begin
				tail = spans_due.pop_back();
				tail.last_of_run = 1'b1;
				spans_due.push_back(tail);
			end
		endfunction

		function void check_span(span_t got);
			span_t want;
			if (spans_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected span, expected none, got %s", $time, span_text(got));
				return;
			end
			want = spans_due.pop_front();
			if (got.x_start !== want.x_start || got.x_end !== want.x_end ||
				got.y !== want.y || got.color !== want.color ||
				got.row_done !== want.row_done || got.last_of_run !== want.last_of_run) begin
				errors++;
				$display("%0t: span mismatch, expected %s, got %s", $time,
					span_text(want), span_text(got));
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	psenc_pixel_if pixel_ch();
	psenc_span_if  span_ch();

	pixel_row_span_encoder_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pixel     (pixel_ch),
		.span      (span_ch)
	);

	span_scoreboard sb = new();

	int sender_idle_pct   = 0;
	int receiver_idle_pct = 0;
	int hold_left         = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Span sink: check at the rising edge, decide ready at the falling edge
	initial begin
		span_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (span_ch.valid && span_ch.ready)
				sb.check_span({span_ch.span_x_start, span_ch.span_x_end, span_ch.span_y,
					span_ch.span_color, span_ch.row_done, span_ch.last_of_run});
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				span_ch.ready <= 1'b0;
			end else begin
				span_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
			end
		end
	end

	// Abort when no transfer happens on either channel for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((pixel_ch.valid && pixel_ch.ready) || (span_ch.valid && span_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic write_cfg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_pixel(logic [COLOR_W-1:0] color, logic [ROW_W-1:0] ry);
		while ($urandom_range(99) < sender_idle_pct) begin
			@(negedge clk);
			pixel_ch.valid <= 1'b0;
		end
		@(negedge clk);
		pixel_ch.valid       <= 1'b1;
		pixel_ch.pixel_color <= color;
		pixel_ch.row_y       <= ry;
		@(posedge clk);
		while (!pixel_ch.ready)
			@(posedge clk);
		sb.note_pixel(color, ry);
	endtask

	// Drop valid, drain every expected span, then let the pipeline go quiet
	task automatic settle();
		@(negedge clk);
		pixel_ch.valid <= 1'b0;
		while (sb.spans_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_config();
		int unsigned w;
		int unsigned fx;
		int unsigned lx;
		w = ($urandom_range(3) == 0) ? $urandom_range(200) : $urandom_range(40);
		case ($urandom_range(7))
		0: begin
			fx = 0;
			lx = 1023;
		end
		1: begin
			fx = 1023 - w;
			lx = 1023;
		end
		2: begin
			fx = $urandom_range(1023, 1);
			lx = $urandom_range(fx - 1);
		end
		3: begin
			fx = 0;
			lx = w;
		end
		default: begin
			fx = $urandom_range(1023 - w);
			lx = fx + w;
		end
		endcase
		write_cfg(REG_FIRST_X, CFG_DATA_W'(fx));
		write_cfg(REG_LAST_X, CFG_DATA_W'(lx));
		write_cfg(REG_X_REPEAT, CFG_DATA_W'(($urandom_range(4) == 0) ?
			$urandom_range(15) : $urandom_range(8, 1)));
		write_cfg(REG_Y_REPEAT, CFG_DATA_W'(($urandom_range(4) == 0) ?
			$urandom_range(15) : $urandom_range(3, 1)));
		write_cfg(REG_BACKGROUND_COLOR, CFG_DATA_W'($urandom_range(7)));
	endtask

	// Rows keep one row_y; now and then row_y jumps mid-row as noise
	task automatic send_rows(int count);
		logic [ROW_W-1:0]   ry;
		logic [COLOR_W-1:0] color;
		ry    = ROW_W'($urandom_range(1023));
		color = COLOR_W'($urandom_range(7));
		repeat (count) begin
			if (!sb.run_open || $urandom_range(9) == 0)
				ry = ROW_W'($urandom_range(1023));
			case ($urandom_range(19))
			0, 1, 2, 3, 4, 5, 6: color = COLOR_W'($urandom_range(7));
			7, 8, 9: color = sb.bg_color;
			default: ;
			endcase
			send_pixel(color, ry);
		end
	endtask

	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_index            = REG_FIRST_X;
		cfg_wdata            = '0;
		pixel_ch.valid       = 1'b0;
		pixel_ch.pixel_color = '0;
		pixel_ch.row_y       = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: colour change emits, background run stays silent
		send_pixel(3'd5, 10'd0);
		send_pixel(3'd5, 10'd1023);
		send_pixel(3'd0, 10'd1023);
		send_pixel(3'd7, 10'd512);
		send_pixel(3'd7, 10'd512);
		settle();

		// Colour change and row end on one pixel, eight copies each, top rows
		write_cfg(REG_LAST_X, 10'd6);
		write_cfg(REG_Y_REPEAT, 10'd8);
		write_cfg(REG_X_REPEAT, 10'd15);
		send_pixel(3'd2, 10'd1023);
		settle();

		// Lower last_x mid-row so the closing run opens beyond it
		write_cfg(REG_LAST_X, 10'd1023);
		write_cfg(REG_X_REPEAT, 10'd1);
		write_cfg(REG_Y_REPEAT, 10'd1);
		send_pixel(3'd4, 10'd10);
		send_pixel(3'd4, 10'd10);
		send_pixel(3'd4, 10'd10);
		send_pixel(3'd6, 10'd10);
		settle();
		write_cfg(REG_LAST_X, 10'd2);
		send_pixel(3'd1, 10'd10);
		send_pixel(3'd1, 10'd10);
		settle();

		// first_x beyond last_x: every pixel is a row; repeats of zero clamp up
		write_cfg(REG_FIRST_X, 10'd1023);
		write_cfg(REG_LAST_X, 10'd0);
		write_cfg(REG_X_REPEAT, 10'd0);
		write_cfg(REG_Y_REPEAT, 10'd0);
		write_cfg(REG_BACKGROUND_COLOR, 10'd7);
		send_pixel(3'd7, 10'd1023);
		send_pixel(3'd0, 10'd0);
		send_pixel(3'd3, 10'd511);
		settle();

		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
			0: begin
				sender_idle_pct   = 36;
				receiver_idle_pct = 72;
			end
			1: begin
				sender_idle_pct   = 72;
				receiver_idle_pct = 36;
			end
			default: begin
				sender_idle_pct   = 0;
				receiver_idle_pct = 0;
			end
			endcase
			for (int phase = 0; phase < 4; phase++) begin
				random_config();
				if (mode == 2 && phase == 1) begin
					// hold the sink off so the command queue fills and stalls input
					write_cfg(REG_Y_REPEAT, 10'd8);
					hold_left = PRESSURE_CYCLES;
				end
				send_rows(PHASE_PIXELS);
				settle();
			end
		end

		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
